>>> rtl/hase_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hase_pkg
// Shared types, widths, codes and constant tables of the successor expansion
// pipeline.
// ----------------------------------------------------------------------------
package hase_pkg;

    // CORDIC
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int XY_W              = 34;   // Q2.30 vector plus headroom
    localparam int SC_W              = 18;   // Q1.14 sine and cosine
    localparam int GEO_W             = 19;   // signed Q2.16 step offsets
    localparam int PROD_W            = GEO_W + SC_W;

    localparam logic signed [XY_W-1:0] CORDIC_START_X = 34'sd652032874;

    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Cost
    localparam int COST_W    = 32;
    localparam int PEN_W     = 16;
    localparam int STEP_W    = 18;
    localparam int TURN_W    = 14;
    localparam int PEN_COUNT = 3;
    localparam int PEN_TURN  = 0;
    localparam int PEN_REV   = 1;
    localparam int PEN_DIR   = 2;

    // Configuration
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [STEP_W-1:0] RST_STRAIGHT_STEP = 18'd45875;
    localparam logic [STEP_W-1:0] RST_ARC_ADVANCE   = 18'd43108;
    localparam logic [STEP_W-1:0] RST_ARC_OFFSET    = 18'd15690;
    localparam logic [TURN_W-1:0] RST_TURN_ANGLE    = 14'd3641;
    localparam logic [PEN_W-1:0]  RST_PENALTY_TURN  = 16'd4301;
    localparam logic [PEN_W-1:0]  RST_PENALTY_REV   = 16'd8192;
    localparam logic [PEN_W-1:0]  RST_PENALTY_DIR   = 16'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRAIGHT_STEP = 3'd0,
        CFG_ARC_ADVANCE   = 3'd1,
        CFG_ARC_OFFSET    = 3'd2,
        CFG_TURN_ANGLE    = 3'd3,
        CFG_PENALTY_TURN  = 3'd4,
        CFG_PENALTY_REV   = 3'd5,
        CFG_PENALTY_DIR   = 3'd6
    } cfg_reg_t;

    // Motion primitive codes; the two top codes are reverse shapes as well
    localparam logic [2:0] PRIM_STRAIGHT      = 3'd0;
    localparam logic [2:0] PRIM_LEFT          = 3'd1;
    localparam logic [2:0] PRIM_RIGHT         = 3'd2;
    localparam logic [2:0] PRIM_REV_STRAIGHT  = 3'd3;
    localparam logic [2:0] PRIM_REV_LEFT      = 3'd4;
    localparam logic [2:0] PRIM_REV_RIGHT     = 3'd5;
    localparam logic [2:0] PRIM_REV_STRAIGHT2 = 3'd6;
    localparam logic [2:0] PRIM_REV_LEFT2     = 3'd7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic [31:0]        path_cost;
        logic [2:0]         parent_prim;
        logic [2:0]         chosen_prim;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] succ_x;
        logic signed [31:0] succ_y;
        logic [15:0]        succ_heading;
        logic [31:0]        succ_cost;
        logic               cost_saturated;
    } out_item_t;

    // Data that rides alongside the CORDIC stages
    typedef struct packed {
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic [COST_W-1:0]       path_cost;
        logic [15:0]             succ_heading;
        logic signed [GEO_W-1:0] lon;
        logic signed [GEO_W-1:0] lat;
    } side_t;

    typedef struct packed {
        logic [STEP_W-1:0]               step;
        logic [PEN_COUNT-1:0][PEN_W-1:0] pen;
    } cost_cfg_t;

    typedef struct packed {
        logic [COST_W-1:0] inc;
        logic              sat;
    } cost_res_t;

endpackage

>>> rtl/hase_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hase_delay
// Register line that keeps side data in step with the main pipeline.
// ----------------------------------------------------------------------------
module hase_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             adv,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

>>> rtl/hase_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hase_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, then rounding of
// sine and cosine to Q1.14 with the half-turn fold undone.
// ----------------------------------------------------------------------------
module hase_cordic
    import hase_pkg::*;
#(
    parameter int ITERS = DEF_CORDIC_STAGES
) (
    input  logic                   clk,
    input  logic                   adv,
    input  logic [15:0]            heading,
    output logic signed [SC_W-1:0] sin_q14,
    output logic signed [SC_W-1:0] cos_q14
);

    localparam logic signed [XY_W-1:0] RND_HALF = XY_W'(32768);

    logic [31:0]            angle;
    logic                   fold;
    logic signed [XY_W-1:0] x_in [ITERS];
    logic signed [XY_W-1:0] y_in [ITERS];
    logic signed [XY_W-1:0] z_in [ITERS];
    logic                   f_in [ITERS];
    logic signed [XY_W-1:0] x_next [ITERS];
    logic signed [XY_W-1:0] y_next [ITERS];
    logic signed [XY_W-1:0] z_next [ITERS];
    logic signed [XY_W-1:0] x_reg [ITERS];
    logic signed [XY_W-1:0] y_reg [ITERS];
    logic signed [XY_W-1:0] z_reg [ITERS];
    logic                   flip_reg [ITERS];
    logic signed [XY_W-1:0] x_rnd;
    logic signed [XY_W-1:0] y_rnd;
    logic signed [SC_W-1:0] c_val;
    logic signed [SC_W-1:0] s_val;
    logic signed [SC_W-1:0] sin_reg;
    logic signed [SC_W-1:0] cos_reg;

    // fold into [-90, 90) degrees by moving half a turn
    assign fold  = heading[15] ^ heading[14];
    assign angle = {heading[15] ^ fold, heading[14:0], 16'h0000};

    genvar i;
    generate
        for (i = 0; i < ITERS; i++)
        begin : g_iter
            if (i == 0)
            begin : g_first
                assign x_in[i] = CORDIC_START_X;
                assign y_in[i] = '0;
                assign z_in[i] = signed'({{(XY_W-32){angle[31]}}, angle});
                assign f_in[i] = fold;
            end
            else
            begin : g_next
                assign x_in[i] = x_reg[i-1];
                assign y_in[i] = y_reg[i-1];
                assign z_in[i] = z_reg[i-1];
                assign f_in[i] = flip_reg[i-1];
            end

            always_comb
            begin
                if (z_in[i] >= 0)
                begin
                    x_next[i] = x_in[i] - (y_in[i] >>> i);
                    y_next[i] = y_in[i] + (x_in[i] >>> i);
                    z_next[i] = z_in[i] - signed'({{(XY_W-32){1'b0}}, ATAN_TABLE[i]});
                end
                else
                begin
                    x_next[i] = x_in[i] + (y_in[i] >>> i);
                    y_next[i] = y_in[i] - (x_in[i] >>> i);
                    z_next[i] = z_in[i] + signed'({{(XY_W-32){1'b0}}, ATAN_TABLE[i]});
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ITERS; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                flip_reg[k] <= f_in[k];
            end
        end
    end

    // round half up to Q1.14
    assign x_rnd = (x_reg[ITERS-1] + RND_HALF) >>> 16;
    assign y_rnd = (y_reg[ITERS-1] + RND_HALF) >>> 16;
    assign c_val = signed'(x_rnd[SC_W-1:0]);
    assign s_val = signed'(y_rnd[SC_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= flip_reg[ITERS-1] ? -c_val : c_val;
            sin_reg <= flip_reg[ITERS-1] ? -s_val : s_val;
        end
    end

    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;

endmodule

>>> rtl/hase_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hase_cost
// Cost increment: up to three Q4.12 penalty products in a fixed order, each
// one multiply stage and one round-and-saturate stage.
// ----------------------------------------------------------------------------
module hase_cost
    import hase_pkg::*;
(
    input  logic                 clk,
    input  logic                 adv,
    input  cost_cfg_t            cfg,
    input  logic [PEN_COUNT-1:0] sel,
    output cost_res_t            result
);

    localparam int MUL_W = COST_W + PEN_W;

    logic [COST_W-1:0]    v_in [PEN_COUNT];
    logic                 sat_in [PEN_COUNT];
    logic [PEN_COUNT-1:0] sel_in [PEN_COUNT];
    logic [MUL_W:0]       rnd_sum [PEN_COUNT];
    logic [MUL_W-12:0]    rnd_val [PEN_COUNT];
    logic                 over [PEN_COUNT];
    logic [COST_W-1:0]    v_next [PEN_COUNT];
    logic                 sat_next [PEN_COUNT];

    logic [MUL_W-1:0]     prod_reg [PEN_COUNT];
    logic [COST_W-1:0]    vm_reg [PEN_COUNT];
    logic                 satm_reg [PEN_COUNT];
    logic [PEN_COUNT-1:0] selm_reg [PEN_COUNT];
    logic [COST_W-1:0]    vr_reg [PEN_COUNT];
    logic                 satr_reg [PEN_COUNT];
    logic [PEN_COUNT-1:0] selr_reg [PEN_COUNT];

    always_comb
    begin
        v_in[0]   = COST_W'(cfg.step);
        sat_in[0] = 1'b0;
        sel_in[0] = sel;
        for (int k = 1; k < PEN_COUNT; k++)
        begin
            v_in[k]   = vr_reg[k-1];
            sat_in[k] = satr_reg[k-1];
            sel_in[k] = selr_reg[k-1];
        end
        for (int k = 0; k < PEN_COUNT; k++)
        begin
            rnd_sum[k] = {1'b0, prod_reg[k]} + (MUL_W+1)'(2048);
            rnd_val[k] = rnd_sum[k][MUL_W:12];
            over[k]    = |rnd_val[k][MUL_W-12:COST_W];
            if (!selm_reg[k][k])
            begin
                v_next[k]   = vm_reg[k];
                sat_next[k] = satm_reg[k];
            end
            else if (over[k])
            begin
                v_next[k]   = '1;
                sat_next[k] = 1'b1;
            end
            else
            begin
                v_next[k]   = rnd_val[k][COST_W-1:0];
                sat_next[k] = satm_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < PEN_COUNT; k++)
            begin
                prod_reg[k] <= v_in[k] * cfg.pen[k];
                vm_reg[k]   <= v_in[k];
                satm_reg[k] <= sat_in[k];
                selm_reg[k] <= sel_in[k];
                vr_reg[k]   <= v_next[k];
                satr_reg[k] <= sat_next[k];
                selr_reg[k] <= selm_reg[k];
            end
        end
    end

    assign result.inc = vr_reg[PEN_COUNT-1];
    assign result.sat = satr_reg[PEN_COUNT-1];

endmodule

>>> rtl/hybrid_astar_successor_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_astar_successor_expand
// Hybrid A* node expansion: successor pose and accumulated cost for one
// parent and one chosen motion primitive per item.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle unless the output stalls, and
// returns exactly one result item per input item, in order. The pipeline is
// one decode stage, one CORDIC iteration per stage, a sine/cosine rounding
// stage, an offset multiply stage, an offset rounding stage and the output
// register; the penalty products of the cost run alongside in six stages of
// their own. A stall on the output holds the whole pipeline, valid bits
// included, so nothing is lost or repeated; in_stall is raised only while a
// finished item waits in the output register and the consumer stalls.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only happen while the pipeline holds no item; an index past the register
// list is ignored.
// ----------------------------------------------------------------------------
module hybrid_astar_successor_expand
    import hase_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // iterations beyond the arctangent table add nothing
    localparam int ITERS    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int COST_LAT = 2 * PEN_COUNT;
    localparam int LAST     = ITERS + 4;

    localparam logic signed [PROD_W:0] RND14 = (PROD_W+1)'(8192);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] straight_step_reg;
    logic [STEP_W-1:0] arc_advance_reg;
    logic [STEP_W-1:0] arc_offset_reg;
    logic [TURN_W-1:0] turn_angle_reg;
    logic [PEN_W-1:0]  penalty_turn_reg;
    logic [PEN_W-1:0]  penalty_rev_reg;
    logic [PEN_W-1:0]  penalty_dir_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_step_reg <= RST_STRAIGHT_STEP;
            arc_advance_reg   <= RST_ARC_ADVANCE;
            arc_offset_reg    <= RST_ARC_OFFSET;
            turn_angle_reg    <= RST_TURN_ANGLE;
            penalty_turn_reg  <= RST_PENALTY_TURN;
            penalty_rev_reg   <= RST_PENALTY_REV;
            penalty_dir_reg   <= RST_PENALTY_DIR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_STRAIGHT_STEP: straight_step_reg <= cfg_data[STEP_W-1:0];
                CFG_ARC_ADVANCE:   arc_advance_reg   <= cfg_data[STEP_W-1:0];
                CFG_ARC_OFFSET:    arc_offset_reg    <= cfg_data[STEP_W-1:0];
                CFG_TURN_ANGLE:    turn_angle_reg    <= cfg_data[TURN_W-1:0];
                CFG_PENALTY_TURN:  penalty_turn_reg  <= cfg_data[PEN_W-1:0];
                CFG_PENALTY_REV:   penalty_rev_reg   <= cfg_data[PEN_W-1:0];
                CFG_PENALTY_DIR:   penalty_dir_reg   <= cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the output item is
    // held by the consumer.
    // ------------------------------------------------------------------
    logic            adv;
    logic [LAST:0]   vld_reg;

    assign adv       = !(vld_reg[LAST] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: decode the primitive into offsets, heading change and the
    // set of penalties to apply.
    // ------------------------------------------------------------------
    logic                    is_left;
    logic                    is_right;
    logic                    rev;
    logic                    parent_rev;
    logic [STEP_W-1:0]       lon_mag;
    logic signed [GEO_W-1:0] lon_fwd;
    logic signed [GEO_W-1:0] lat_off;
    logic [15:0]             dturn;
    side_t                   side_next;
    logic [PEN_COUNT-1:0]    sel_next;

    side_t                   side_s0_reg;
    logic [15:0]             heading_s0_reg;
    logic [PEN_COUNT-1:0]    sel_s0_reg;

    always_comb
    begin
        is_left  = 1'b0;
        is_right = 1'b0;
        case (in_item.chosen_prim)
            PRIM_LEFT, PRIM_REV_LEFT, PRIM_REV_LEFT2:
                is_left = 1'b1;
            PRIM_RIGHT, PRIM_REV_RIGHT:
                is_right = 1'b1;
            PRIM_STRAIGHT, PRIM_REV_STRAIGHT, PRIM_REV_STRAIGHT2:
                ;
            default: ;
        endcase

        rev        = in_item.chosen_prim >= PRIM_REV_STRAIGHT;
        parent_rev = in_item.parent_prim >= PRIM_REV_STRAIGHT;

        lon_mag = (is_left || is_right) ? arc_advance_reg : straight_step_reg;
        lon_fwd = signed'({1'b0, lon_mag});

        if (is_left)
            lat_off = -signed'({1'b0, arc_offset_reg});
        else if (is_right)
            lat_off = signed'({1'b0, arc_offset_reg});
        else
            lat_off = '0;

        if (is_left)
            dturn = {2'b00, turn_angle_reg};
        else if (is_right)
            dturn = 16'(-{2'b00, turn_angle_reg});
        else
            dturn = '0;
        if (rev)
            dturn = 16'(-dturn);

        side_next.pos_x        = in_item.pos_x;
        side_next.pos_y        = in_item.pos_y;
        side_next.path_cost    = in_item.path_cost;
        side_next.succ_heading = in_item.heading + dturn;
        side_next.lon          = rev ? -lon_fwd : lon_fwd;
        side_next.lat          = lat_off;

        // turn on any change of primitive, reverse whenever backing up,
        // direction change when the travel sense flips
        sel_next[PEN_TURN] = in_item.chosen_prim != in_item.parent_prim;
        sel_next[PEN_REV]  = rev;
        sel_next[PEN_DIR]  = rev != parent_rev;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_s0_reg    <= side_next;
            heading_s0_reg <= in_item.heading;
            sel_s0_reg     <= sel_next;
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine, with the side data carried to the same stage
    // ------------------------------------------------------------------
    logic signed [SC_W-1:0] sin_c;
    logic signed [SC_W-1:0] cos_c;
    side_t                  side_c;

    hase_cordic #(
        .ITERS (ITERS)
    ) u_cordic (
        .clk     (clk),
        .adv     (adv),
        .heading (heading_s0_reg),
        .sin_q14 (sin_c),
        .cos_q14 (cos_c)
    );

    hase_delay #(
        .WIDTH ($bits(side_t)),
        .DEPTH (ITERS + 1)
    ) u_side_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (side_s0_reg),
        .dout (side_c)
    );

    // ------------------------------------------------------------------
    // Cost increment, then delay it to the offset rounding stage
    // ------------------------------------------------------------------
    cost_cfg_t cost_cfg;
    cost_res_t cost_res;
    cost_res_t cost_d;

    assign cost_cfg.step          = straight_step_reg;
    assign cost_cfg.pen[PEN_TURN] = penalty_turn_reg;
    assign cost_cfg.pen[PEN_REV]  = penalty_rev_reg;
    assign cost_cfg.pen[PEN_DIR]  = penalty_dir_reg;

    hase_cost u_cost (
        .clk    (clk),
        .adv    (adv),
        .cfg    (cost_cfg),
        .sel    (sel_s0_reg),
        .result (cost_res)
    );

    hase_delay #(
        .WIDTH ($bits(cost_res_t)),
        .DEPTH (ITERS + 3 - COST_LAT)
    ) u_cost_dly (
        .clk  (clk),
        .adv  (adv),
        .din  (cost_res),
        .dout (cost_d)
    );

    // ------------------------------------------------------------------
    // Rotate the step offsets: four products, then sum and round to Q16.16
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p_lon_cos_reg;
    logic signed [PROD_W-1:0] p_lat_sin_reg;
    logic signed [PROD_W-1:0] p_lon_sin_reg;
    logic signed [PROD_W-1:0] p_lat_cos_reg;
    side_t                    side_g_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_lon_cos_reg <= side_c.lon * cos_c;
            p_lat_sin_reg <= side_c.lat * sin_c;
            p_lon_sin_reg <= side_c.lon * sin_c;
            p_lat_cos_reg <= side_c.lat * cos_c;
            side_g_reg    <= side_c;
        end
    end

    logic signed [PROD_W:0] dx_sum;
    logic signed [PROD_W:0] dy_sum;
    logic signed [PROD_W:0] dx_rnd;
    logic signed [PROD_W:0] dy_rnd;
    logic [31:0]            dx_reg;
    logic [31:0]            dy_reg;
    side_t                  side_r_reg;

    assign dx_sum = (PROD_W+1)'(p_lon_cos_reg) - (PROD_W+1)'(p_lat_sin_reg);
    assign dy_sum = (PROD_W+1)'(p_lon_sin_reg) + (PROD_W+1)'(p_lat_cos_reg);
    assign dx_rnd = (dx_sum + RND14) >>> 14;
    assign dy_rnd = (dy_sum + RND14) >>> 14;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg     <= dx_rnd[31:0];
            dy_reg     <= dy_rnd[31:0];
            side_r_reg <= side_g_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: wrap the position, saturate the cost
    // ------------------------------------------------------------------
    logic [COST_W:0] cost_sum;
    out_item_t       out_next;
    out_item_t       out_reg;

    always_comb
    begin
        cost_sum                = {1'b0, side_r_reg.path_cost} + {1'b0, cost_d.inc};
        out_next.succ_x         = side_r_reg.pos_x + signed'(dx_reg);
        out_next.succ_y         = side_r_reg.pos_y + signed'(dy_reg);
        out_next.succ_heading   = side_r_reg.succ_heading;
        out_next.succ_cost      = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
        out_next.cost_saturated = cost_d.sat | cost_sum[COST_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the hybrid A* successor expansion pipeline.
// Node items go in through a valid/stall channel with random gaps. Every
// accepted item is run through a local successor predictor, which holds its
// own copy of the configuration registers. The expected successor is queued,
// and each result item is checked field by field against the oldest entry.
// Register settings change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
    import hase_pkg::*;

    localparam int STAGES         = DEF_CORDIC_STAGES;
    // Accept-to-result delay of the block: one decode, one stage per
    // CORDIC iteration, rounding, multiply, rounding, output register.
    localparam int PIPE_LATENCY   = STAGES + 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 280;
    localparam longint unsigned COST_LIMIT = 64'h0000_0000_FFFF_FFFF;
    // Register index past the end of the list; the block drops such writes
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the configuration registers, at the block's widths
    logic [STEP_W-1:0] step_reg = RST_STRAIGHT_STEP;
    logic [STEP_W-1:0] adv_reg  = RST_ARC_ADVANCE;
    logic [STEP_W-1:0] off_reg  = RST_ARC_OFFSET;
    logic [TURN_W-1:0] turn_reg = RST_TURN_ANGLE;
    logic [PEN_W-1:0]  pen_turn = RST_PENALTY_TURN;
    logic [PEN_W-1:0]  pen_rev  = RST_PENALTY_REV;
    logic [PEN_W-1:0]  pen_dir  = RST_PENALTY_DIR;

    out_item_t  succ_q[$];
    int         errors       = 0;
    idle_mode_t tx_idle      = IDLE_FULL;
    idle_mode_t rx_idle      = IDLE_FULL;
    logic       hold_results = 1'b0;

    hybrid_astar_successor_expand #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Multiply a cost increment by a Q4.12 penalty, round half up, clip to
    // the cost range and flag the clip.
    function automatic longint unsigned scale_q12(input longint unsigned v,
                                                  input logic [PEN_W-1:0] pen,
                                                  inout bit sat);
        longint unsigned r;
        r = (v * pen + 2048) >> 12;
        if (r > COST_LIMIT)
        begin
            sat = 1'b1;
            r   = COST_LIMIT;
        end
        return r;
    endfunction

    function automatic out_item_t expand_node(input in_item_t node);
        out_item_t       succ;
        logic [31:0]     ang;
        logic [31:0]     folded;
        logic [15:0]     dturn;
        logic [2:0]      shape;
        bit              flip;
        bit              rev;
        bit              parent_rev;
        bit              sat;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          sin_q14;
        longint          cos_q14;
        longint          lon;
        longint          lat;
        longint          dx;
        longint          dy;
        longint unsigned inc;
        longint unsigned total;

        // Primitive shape and direction; the two top codes are reverse too
        rev        = node.chosen_prim >= PRIM_REV_STRAIGHT;
        parent_rev = node.parent_prim >= PRIM_REV_STRAIGHT;
        shape      = node.chosen_prim % 3;
        if (shape == PRIM_STRAIGHT)
        begin
            lon   = longint'(step_reg);
            lat   = 0;
            dturn = 16'h0000;
        end
        else if (shape == PRIM_LEFT)
        begin
            lon   = longint'(adv_reg);
            lat   = -longint'(off_reg);
            dturn = {2'b00, turn_reg};
        end
        else
        begin
            lon   = longint'(adv_reg);
            lat   = longint'(off_reg);
            dturn = -{2'b00, turn_reg};
        end
        if (rev)
        begin
            lon   = -lon;
            dturn = -dturn;
        end
        succ.succ_heading = node.heading + dturn;

        // Fold the heading into [-90, 90) degrees, rotate, then undo the fold
        ang    = {node.heading, 16'h0000};
        folded = ang + 32'h4000_0000;
        flip   = folded[31];
        if (flip)
            ang = ang ^ 32'h8000_0000;
        z = longint'($signed(ang));
        x = CORDIC_START_X;
        y = 0;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TABLE[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TABLE[i]);
            end
        end
        cos_q14 = (x + 32768) >>> 16;
        sin_q14 = (y + 32768) >>> 16;
        if (flip)
        begin
            cos_q14 = -cos_q14;
            sin_q14 = -sin_q14;
        end

        // Exact products, one rounding to Q16.16, wrapping add
        dx = (lon * cos_q14 - lat * sin_q14 + 8192) >>> 14;
        dy = (lon * sin_q14 + lat * cos_q14 + 8192) >>> 14;
        succ.succ_x = node.pos_x + dx[31:0];
        succ.succ_y = node.pos_y + dy[31:0];

        // Cost increment: penalties in the order turn, reverse, direction
        sat = 1'b0;
        inc = longint'(step_reg);
        if (node.chosen_prim != node.parent_prim)
        begin
            inc = scale_q12(inc, pen_turn, sat);
            if (rev)
                inc = scale_q12(inc, pen_rev, sat);
            if (rev != parent_rev)
                inc = scale_q12(inc, pen_dir, sat);
        end
        else if (rev)
        begin
            inc = scale_q12(inc, pen_rev, sat);
        end
        total = inc + longint'(node.path_cost);
        if (total > COST_LIMIT)
        begin
            total = COST_LIMIT;
            sat   = 1'b1;
        end
        succ.succ_cost      = total[31:0];
        succ.cost_saturated = sat;
        return succ;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_STRAIGHT_STEP: step_reg = data;
            CFG_ARC_ADVANCE:   adv_reg  = data;
            CFG_ARC_OFFSET:    off_reg  = data;
            CFG_TURN_ANGLE:    turn_reg = data[TURN_W-1:0];
            CFG_PENALTY_TURN:  pen_turn = data[PEN_W-1:0];
            CFG_PENALTY_REV:   pen_rev  = data[PEN_W-1:0];
            CFG_PENALTY_DIR:   pen_dir  = data[PEN_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int draw_wait(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default:   return $urandom_range(0, 19);
        endcase
    endfunction

    function automatic in_item_t make_node(input logic [31:0] px, input logic [31:0] py,
                                           input logic [15:0] hd, input logic [31:0] cost,
                                           input logic [2:0] pp, input logic [2:0] cp);
        in_item_t node;
        node.pos_x       = px;
        node.pos_y       = py;
        node.heading     = hd;
        node.path_cost   = cost;
        node.parent_prim = pp;
        node.chosen_prim = cp;
        return node;
    endfunction

    // Mostly legal primitives, now and then one of the two spare reverse codes
    function automatic logic [2:0] draw_prim();
        if ($urandom_range(0, 15) == 0)
            return PRIM_REV_STRAIGHT2 + $urandom_range(0, 1);
        return $urandom_range(PRIM_STRAIGHT, PRIM_REV_RIGHT);
    endfunction

    function automatic logic [31:0] draw_pos();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 1 << 18);
            1:       return 32'h8000_0000 + $urandom_range(0, 1 << 18);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_node();
        in_item_t node;
        node.pos_x = draw_pos();
        node.pos_y = draw_pos();
        // Half the headings sit within a step of a quadrant boundary
        if ($urandom_range(0, 1) == 0)
            node.heading = $urandom;
        else
            node.heading = {$urandom_range(0, 3), 14'h0000} + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 3) == 0)
            node.path_cost = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
        else
            node.path_cost = $urandom;
        node.parent_prim = draw_prim();
        node.chosen_prim = ($urandom_range(0, 2) == 0) ? node.parent_prim : draw_prim();
        return node;
    endfunction

    // Offer one node item after a drawn gap and hold it until accepted
    task automatic send_node(input in_item_t node);
        int gap;
        gap = draw_wait(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= node;
        do @(posedge clk); while (in_stall);
        succ_q.push_back(expand_node(node));
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_node(rand_node());
        in_valid <= 1'b0;
    endtask

    // Wait until every successor has come back, then let the pipe settle
    task automatic wait_drain();
        while (succ_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // Write one register; leave valid high so writes can run back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_config(idx, data);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] step,
                                input logic [CFG_DATA_W-1:0] adv,
                                input logic [CFG_DATA_W-1:0] off,
                                input logic [CFG_DATA_W-1:0] turn,
                                input logic [CFG_DATA_W-1:0] pt,
                                input logic [CFG_DATA_W-1:0] pr,
                                input logic [CFG_DATA_W-1:0] pd);
        wait_drain();
        write_reg(CFG_STRAIGHT_STEP, step);
        write_reg(CFG_ARC_ADVANCE, adv);
        write_reg(CFG_ARC_OFFSET, off);
        write_reg(CFG_TURN_ANGLE, turn);
        write_reg(CFG_PENALTY_TURN, pt);
        write_reg(CFG_PENALTY_REV, pr);
        write_reg(CFG_PENALTY_DIR, pd);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: every primitive code, quadrant edges of the heading,
    // wrapping positions and a saturating path cost.
    task automatic test_directed();
        tx_idle = IDLE_SOME;
        rx_idle = IDLE_SOME;
        send_node(make_node(0, 0, 16'h0000, 0, PRIM_STRAIGHT, PRIM_STRAIGHT));
        send_node(make_node(0, 0, 16'h4000, 0, PRIM_STRAIGHT, PRIM_LEFT));
        send_node(make_node(0, 0, 16'h8000, 0, PRIM_LEFT, PRIM_RIGHT));
        send_node(make_node(0, 0, 16'hC000, 0, PRIM_RIGHT, PRIM_REV_STRAIGHT));
        send_node(make_node(0, 0, 16'hFFFF, 0, PRIM_REV_LEFT, PRIM_REV_LEFT));
        send_node(make_node(0, 0, 16'h3FFF, 0, PRIM_REV_STRAIGHT, PRIM_REV_RIGHT));
        send_node(make_node(0, 0, 16'h4001, 0, PRIM_REV_LEFT2, PRIM_REV_STRAIGHT2));
        send_node(make_node(0, 0, 16'hBFFF, 0, PRIM_REV_LEFT2, PRIM_REV_LEFT2));
        send_node(make_node(0, 0, 16'hC001, 0, PRIM_STRAIGHT, PRIM_REV_LEFT2));
        send_node(make_node(0, 0, 16'h7FFF, 0, PRIM_REV_RIGHT, PRIM_LEFT));
        send_node(make_node(0, 0, 16'h8001, 0, PRIM_REV_STRAIGHT2, PRIM_STRAIGHT));
        // Positions wrap past both ends
        send_node(make_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 0,
                            PRIM_STRAIGHT, PRIM_STRAIGHT));
        send_node(make_node(32'h8000_0000, 32'h8000_0000, 16'h2000, 0,
                            PRIM_REV_STRAIGHT, PRIM_REV_STRAIGHT));
        send_node(make_node(32'hFFFF_FFFF, 32'h0000_0001, 16'hE000, 0,
                            PRIM_RIGHT, PRIM_RIGHT));
        // Cost sum at and just below the top of the range
        send_node(make_node(0, 0, 16'h0000, 32'hFFFF_FFFF, PRIM_STRAIGHT, PRIM_STRAIGHT));
        send_node(make_node(0, 0, 16'h0000, 32'hFFFF_0000, PRIM_STRAIGHT, PRIM_REV_LEFT));
        send_node(make_node(0, 0, 16'h6000, 32'hFFFF_4CD2, PRIM_LEFT, PRIM_LEFT));
        send_node(make_node(32'h0123_4567, 32'hFEDC_BA98, 16'hA5A5, 32'h5A5A_5A5A,
                            PRIM_REV_RIGHT, PRIM_RIGHT));
        in_valid <= 1'b0;
    endtask

    // All registers at the top of their range, then all at zero
    task automatic test_register_extremes();
        write_config(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF,
                     18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
        send_node(make_node(0, 0, 16'h0000, 0, PRIM_STRAIGHT, PRIM_REV_LEFT));
        send_node(make_node(0, 0, 16'h2000, 0, PRIM_REV_RIGHT, PRIM_RIGHT));
        send_node(make_node(0, 0, 16'hE000, 0, PRIM_LEFT, PRIM_REV_LEFT2));
        send_random(100);
        write_config(0, 0, 0, 0, 0, 0, 0);
        send_random(100);
    endtask

    // A write to an index past the list must leave every register alone
    task automatic test_ignored_index();
        wait_drain();
        write_reg(CFG_UNUSED, $urandom_range(0, 18'h3FFFF));
        cfg_valid <= 1'b0;
        send_random(30);
    endtask

    // Random settings per phase, idling varied from none to heavy
    task automatic test_random_settings();
        idle_mode_t tx_modes[5] = '{IDLE_FULL, IDLE_NONE, IDLE_SOME, IDLE_FULL, IDLE_SOME};
        idle_mode_t rx_modes[5] = '{IDLE_FULL, IDLE_NONE, IDLE_FULL, IDLE_NONE, IDLE_SOME};
        for (int p = 0; p < 5; p++)
        begin
            write_config($urandom_range(0, 18'h3FFFF), $urandom_range(0, 18'h3FFFF),
                         $urandom_range(0, 18'h3FFFF), $urandom_range(0, 18'h3FFFF),
                         $urandom_range(0, 18'h3FFFF), $urandom_range(0, 18'h3FFFF),
                         $urandom_range(0, 18'h3FFFF));
            tx_idle = tx_modes[p];
            rx_idle = rx_modes[p];
            send_random(PHASE_ITEMS);
        end
    endtask

    // Hold the result side off long enough for the pipe to fill and stall
    // its input while items keep coming; then pause the sender until the
    // pipe has drained and carry on with gaps.
    task automatic test_backpressure();
        write_config(RST_STRAIGHT_STEP, RST_ARC_ADVANCE, RST_ARC_OFFSET, RST_TURN_ANGLE,
                     RST_PENALTY_TURN, RST_PENALTY_REV, RST_PENALTY_DIR);
        tx_idle = IDLE_NONE;
        rx_idle = IDLE_NONE;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
            send_random(80);
        join
        wait_drain();
        tx_idle = IDLE_FULL;
        rx_idle = IDLE_SOME;
        send_random(40);
    endtask

    // ------------------------------------------------------------------------
    // Result checking: drive the stall, compare each accepted result item
    // ------------------------------------------------------------------------
    initial
    begin : result_check
        out_item_t want;
        int        stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (succ_q.size() == 0)
                begin
                    $error("result item with no successor expected");
                    errors++;
                end
                else
                begin
                    want = succ_q.pop_front();
                    if (out_item.succ_x !== want.succ_x)
                    begin
                        $error("succ_x: expected %0d, got %0d", want.succ_x, out_item.succ_x);
                        errors++;
                    end
                    if (out_item.succ_y !== want.succ_y)
                    begin
                        $error("succ_y: expected %0d, got %0d", want.succ_y, out_item.succ_y);
                        errors++;
                    end
                    if (out_item.succ_heading !== want.succ_heading)
                    begin
                        $error("succ_heading: expected %h, got %h",
                               want.succ_heading, out_item.succ_heading);
                        errors++;
                    end
                    if (out_item.succ_cost !== want.succ_cost)
                    begin
                        $error("succ_cost: expected %h, got %h",
                               want.succ_cost, out_item.succ_cost);
                        errors++;
                    end
                    if (out_item.cost_saturated !== want.cost_saturated)
                    begin
                        $error("cost_saturated: expected %b, got %b",
                               want.cost_saturated, out_item.cost_saturated);
                        errors++;
                    end
                end
                stall_left = draw_wait(rx_idle);
            end
            // One assignment per edge: long hold-off first, then drawn stall
            if (hold_results)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no channel moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("hybrid_astar_successor_expand regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_ignored_index();
        test_random_settings();
        test_backpressure();

        wait_drain();
        if (errors == 0)
            $display("hybrid_astar_successor_expand regression: pass");
        else
            $display("hybrid_astar_successor_expand regression: fail");
        $finish;
    end

endmodule
